/* rtl/spcb_pkg.sv */
// Shared types, constants and channel map of the servo pulse command builder.
`default_nettype none

package spcb_pkg;

  localparam int LEG_COUNT   = 6;
  localparam int MOTOR_COUNT = 18;

  localparam int ANGLE_W  = 17;
  localparam int LEG_W    = 3;
  localparam int PULSE_W  = 12;
  localparam int CHAN_W   = 5;
  localparam int CFG_W    = 12;
  localparam int CFG_IDX_W = 3;
  localparam int JOINT_COUNT = 3;

  localparam int MIDX_W   = 5;
  localparam int STORE_AW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int MAP_DEPTH = 24;

  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = 1;
  localparam int QCNT_W   = 2;

  // Target = center + raw*25/576; 576 = 64 * 9, divide by 9 via reciprocal.
  localparam int SCALE_NUM   = 25;
  localparam int SHIFT_64    = 6;
  localparam int BIAS_Q      = 4096;
  localparam int BIAS        = 576 * BIAS_Q;
  localparam int PROD25_W    = 23;
  localparam int V_W         = 16;
  localparam int RECIP9      = 58255;
  localparam int RECIP9_SH   = 19;
  localparam int PROD_W      = 32;
  localparam int Q_W         = 13;
  localparam int TGT_W       = 15;

  localparam logic [PULSE_W-1:0] PULSE_RESET = PULSE_W'(1500);

  localparam logic [CHAN_W-1:0] CHAN_MAP [MAP_DEPTH] = '{
    5'd0,  5'd1,  5'd2,  5'd16, 5'd17, 5'd18, 5'd4,  5'd5,
    5'd6,  5'd20, 5'd21, 5'd22, 5'd8,  5'd9,  5'd10, 5'd24,
    5'd25, 5'd26, 5'd12, 5'd13, 5'd14, 5'd28, 5'd29, 5'd30
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIP_MIN   = 3'd0,
    CFG_HIP_MAX   = 3'd1,
    CFG_FEMUR_MIN = 3'd2,
    CFG_FEMUR_MAX = 3'd3,
    CFG_TIBIA_MIN = 3'd4,
    CFG_TIBIA_MAX = 3'd5,
    CFG_CENTER    = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [JOINT_COUNT-1:0][PULSE_W-1:0] lo;
    logic [JOINT_COUNT-1:0][PULSE_W-1:0] hi;
    logic [PULSE_W-1:0]                  center;
  } cfg_t;

  typedef struct packed {
    logic                                send;
    logic [LEG_W-1:0]                    leg;
    logic [JOINT_COUNT-1:0][ANGLE_W-1:0] angle;
  } item_t;

  typedef struct packed {
    logic  push;
    item_t item;
  } enq_t;

endpackage

`default_nettype wire

/* rtl/spcb_front.sv */
// Front end: accepts items, drops updates for absent legs, queues the rest.
`default_nettype none

module spcb_front import spcb_pkg::*; (
  input  wire logic               start,
  input  wire logic               full,
  input  wire logic               in_command,
  input  wire logic [LEG_W-1:0]   in_leg_index,
  input  wire logic [ANGLE_W-1:0] in_angle_first,
  input  wire logic [ANGLE_W-1:0] in_angle_second,
  input  wire logic [ANGLE_W-1:0] in_angle_third,
  output enq_t                    enq
);

  logic accept;
  logic leg_ok;

  always_comb begin
    accept = start && !full;
    leg_ok = ({1'b0, in_leg_index} < (LEG_W + 1)'(LEG_COUNT));
    enq.item.send  = in_command;
    enq.item.leg   = in_leg_index;
    enq.item.angle = {in_angle_third, in_angle_second, in_angle_first};
    enq.push = accept && (in_command || leg_ok);
  end

endmodule

`default_nettype wire

/* rtl/spcb_queue.sv */
// Short item queue between the front end and the executing back end.
`default_nettype none

module spcb_queue import spcb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire enq_t enq,
  input  wire logic pop,
  output logic      full,
  output logic      not_empty,
  output item_t     head
);

  item_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_pop;

  always_comb begin
    full      = (count_r == QCNT_W'(QDEPTH));
    not_empty = (count_r != '0);
    head      = mem[rd_ptr_r];
    do_pop    = pop && not_empty;
    wr_ptr_nxt = enq.push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(enq.push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (enq.push) begin
      mem[wr_ptr_r] <= enq.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/spcb_back.sv */
// Back end: converts joint angles to stored widths and scans out pending moves.
`default_nettype none

module spcb_back import spcb_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cfg_t               cfg,
  input  wire logic               q_not_empty,
  input  wire item_t              q_head,
  output logic                    q_pop,
  output logic                    out_valid,
  output logic [CHAN_W-1:0]       out_channel,
  output logic [PULSE_W-1:0]      out_pulse_width,
  output logic                    out_last_entry
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_WRITE,
    ST_SCAN
  } state_t;

  state_t              state_r;
  item_t               item_r;
  logic [1:0]          joint_r;
  logic [V_W-1:0]      v_r;
  logic                r6_zero_r;
  logic [PROD_W-1:0]   prod_r;
  logic [STORE_AW-1:0] scan_r;
  logic                changed_r;
  logic [PULSE_W-1:0]  pulse_store_r [MOTOR_COUNT];
  logic [MOTOR_COUNT-1:0] pending_r;
  logic                out_valid_r;
  logic [CHAN_W-1:0]   out_channel_r;
  logic [PULSE_W-1:0]  out_pulse_width_r;
  logic                out_last_r;

  logic signed [ANGLE_W-1:0]  raw;
  logic signed [PROD25_W-1:0] t_s;
  logic signed [PROD25_W-1:0] u_s;
  logic [Q_W-1:0]             q;
  logic [V_W:0]               nine_q;
  logic                       exact;
  logic signed [TGT_W-1:0]    tgt;
  logic signed [TGT_W-1:0]    lo_s;
  logic signed [TGT_W-1:0]    hi_s;
  logic signed [TGT_W-1:0]    clamp1;
  logic signed [TGT_W-1:0]    clamp2;
  logic [MIDX_W-1:0]          mot_idx;
  logic                       idx_ok;
  logic [STORE_AW-1:0]        rd_addr;
  logic [PULSE_W-1:0]         stored;
  logic                       same;
  logic                       more_pend;
  logic                       last_scan;

  always_comb begin
    raw = $signed(item_r.angle[joint_r]);
    t_s = PROD25_W'(raw) * PROD25_W'(SCALE_NUM);
    u_s = t_s + PROD25_W'(BIAS);

    q      = prod_r[RECIP9_SH +: Q_W];
    nine_q = {q, 3'b000} + (V_W + 1)'(q);
    exact  = r6_zero_r && (nine_q == {1'b0, v_r});
    tgt    = $signed(TGT_W'(cfg.center)) + $signed(TGT_W'(q)) - TGT_W'(BIAS_Q);

    mot_idx = MIDX_W'(item_r.leg) * MIDX_W'(JOINT_COUNT) + MIDX_W'(joint_r);
    idx_ok  = (mot_idx < MIDX_W'(MOTOR_COUNT));
    rd_addr = (state_r == ST_SCAN) ? scan_r : mot_idx[STORE_AW-1:0];
    stored  = pulse_store_r[rd_addr];
    same    = exact && (tgt == $signed(TGT_W'(stored)));

    lo_s   = $signed(TGT_W'(cfg.lo[joint_r]));
    hi_s   = $signed(TGT_W'(cfg.hi[joint_r]));
    clamp1 = (tgt < lo_s) ? lo_s : tgt;
    clamp2 = (clamp1 > hi_s) ? hi_s : clamp1;

    more_pend = 1'b0;
    for (int k = 0; k < MOTOR_COUNT; k++) begin
      if (pending_r[k] && (STORE_AW'(k) > scan_r)) begin
        more_pend = 1'b1;
      end
    end
    last_scan = (scan_r == STORE_AW'(MOTOR_COUNT - 1));

    q_pop = (state_r == ST_IDLE);

    out_valid       = out_valid_r;
    out_channel     = out_channel_r;
    out_pulse_width = out_pulse_width_r;
    out_last_entry  = out_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      joint_r     <= '0;
      scan_r      <= '0;
      changed_r   <= 1'b1;
      pending_r   <= '1;
      out_valid_r <= 1'b0;
      for (int k = 0; k < MOTOR_COUNT; k++) begin
        pulse_store_r[k] <= PULSE_RESET;
      end
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (q_not_empty) begin
            item_r  <= q_head;
            joint_r <= '0;
            scan_r  <= '0;
            if (!q_head.send) begin
              state_r <= ST_PREP;
            end else if (changed_r) begin
              state_r <= ST_SCAN;
            end
          end
        end
        ST_PREP: begin
          v_r       <= u_s[SHIFT_64 +: V_W];
          r6_zero_r <= (u_s[SHIFT_64-1:0] == '0);
          state_r   <= ST_MUL;
        end
        ST_MUL: begin
          prod_r  <= PROD_W'(v_r) * PROD_W'(RECIP9);
          state_r <= ST_WRITE;
        end
        ST_WRITE: begin
          if (idx_ok && !same) begin
            pulse_store_r[mot_idx[STORE_AW-1:0]] <= clamp2[PULSE_W-1:0];
            pending_r[mot_idx[STORE_AW-1:0]]     <= 1'b1;
            changed_r                            <= 1'b1;
          end
          if (joint_r == 2'(JOINT_COUNT - 1)) begin
            state_r <= ST_IDLE;
          end else begin
            joint_r <= joint_r + 1'b1;
            state_r <= ST_PREP;
          end
        end
        ST_SCAN: begin
          if (pending_r[scan_r]) begin
            out_valid_r       <= 1'b1;
            out_channel_r     <= CHAN_MAP[MIDX_W'(scan_r)];
            out_pulse_width_r <= stored;
            out_last_r        <= !more_pend;
            pending_r[scan_r] <= 1'b0;
          end
          if (last_scan) begin
            changed_r <= 1'b0;
            state_r   <= ST_IDLE;
          end else begin
            scan_r <= scan_r + 1'b1;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/servo_pulse_command_builder.sv */
// Top level of the servo pulse command builder: limit registers and wiring.
//
// Usage: drive start with an item on the in_ ports; it is taken at a clock edge
// where start is high and busy is low. in_command 0 updates the three joint
// widths of leg in_leg_index, 1 sends the pending moves. Updates for a leg
// number at or above the leg count are dropped on entry.
// Accepted items wait in a two-entry queue; busy is high while it is full.
// An update passes through the back end (it is taken from the queue, then
// each of the 3 joints goes through ST_PREP, ST_MUL and ST_WRITE of the shared
// divide-by-576 path) and emits nothing.
// A send with changes pending is taken from the queue and starts a scan of all
// 18 motors, one per cycle. It emits one item per pending motor on out_channel
// / out_pulse_width, marked by out_valid for one cycle. Each item is registered
// and appears in the cycle after its motor is scanned; out_last_entry marks the
// last of the frame. A send with nothing changed is taken from the queue and
// emits nothing. Results are never held; the receiver must take each item when
// out_valid is high. Limit and center registers are written through cfg_we /
// cfg_index / cfg_data; the user must write them only while idle, which the
// block itself does not enforce. Reset sets all widths to 1500, marks every
// motor pending and the frame changed, and loads the default limits.
`default_nettype none

module servo_pulse_command_builder import spcb_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 in_command,
  input  wire logic [LEG_W-1:0]     in_leg_index,
  input  wire logic [ANGLE_W-1:0]   in_angle_first,
  input  wire logic [ANGLE_W-1:0]   in_angle_second,
  input  wire logic [ANGLE_W-1:0]   in_angle_third,
  output logic                      out_valid,
  output logic [CHAN_W-1:0]         out_channel,
  output logic [PULSE_W-1:0]        out_pulse_width,
  output logic                      out_last_entry,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  cfg_t  cfg_r;
  enq_t  enq;
  item_t q_head;
  logic  q_full;
  logic  q_not_empty;
  logic  q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lo[0]  <= PULSE_W'(600);
      cfg_r.hi[0]  <= PULSE_W'(2400);
      cfg_r.lo[1]  <= PULSE_W'(600);
      cfg_r.hi[1]  <= PULSE_W'(1900);
      cfg_r.lo[2]  <= PULSE_W'(1550);
      cfg_r.hi[2]  <= PULSE_W'(2400);
      cfg_r.center <= PULSE_W'(1500);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HIP_MIN:   cfg_r.lo[0]  <= cfg_data;
        CFG_HIP_MAX:   cfg_r.hi[0]  <= cfg_data;
        CFG_FEMUR_MIN: cfg_r.lo[1]  <= cfg_data;
        CFG_FEMUR_MAX: cfg_r.hi[1]  <= cfg_data;
        CFG_TIBIA_MIN: cfg_r.lo[2]  <= cfg_data;
        CFG_TIBIA_MAX: cfg_r.hi[2]  <= cfg_data;
        CFG_CENTER:    cfg_r.center <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign busy = q_full;

  spcb_front u_front (
    .start           (start),
    .full            (q_full),
    .in_command      (in_command),
    .in_leg_index    (in_leg_index),
    .in_angle_first  (in_angle_first),
    .in_angle_second (in_angle_second),
    .in_angle_third  (in_angle_third),
    .enq             (enq)
  );

  spcb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .enq       (enq),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  spcb_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_not_empty     (q_not_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_channel     (out_channel),
    .out_pulse_width (out_pulse_width),
    .out_last_entry  (out_last_entry)
  );

endmodule

`default_nettype wire
